[hdl/wpfe_pkg.sv]
// ----------------------------------------------------------------------------
// wpfe_pkg
// Shared types and constants of the wave pulse field engine.
// ----------------------------------------------------------------------------
package wpfe_pkg;

   // Default size of the pulse table
   localparam int MAX_PULSES_DEF = 16;

   // Action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_EMIT  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SPEED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_RATE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLOFF      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 3'd4;

   // Register reset values
   localparam logic [15:0] TRACK_LENGTH_RST = 16'd3072;
   localparam logic [15:0] WAVE_SPEED_RST   = 16'd3840;
   localparam logic [15:0] DECAY_RATE_RST   = 16'd2048;
   localparam logic [15:0] FALLOFF_RST      = 16'd4608;
   localparam logic [15:0] THRESHOLD_RST    = 16'd1;

   // x / 1000 for any 32-bit x: (x * DIV1000_MAGIC) >> DIV1000_SHIFT
   localparam logic [31:0] DIV1000_MAGIC = 32'h10624DD3;
   localparam int          DIV1000_SHIFT = 38;

   localparam logic [19:0] SUM_MAX = 20'hFFFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] delta_ms;
      logic [15:0] start_intensity;
      logic [15:0] position;
   } req_type;

   typedef struct packed {
      logic [19:0] intensity_sum;
      logic        slot_found;
   } rsp_type;

endpackage

[hdl/wpfe_ram.sv]
// ----------------------------------------------------------------------------
// wpfe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wpfe_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[hdl/wave_pulse_field_engine_top.sv]
// ----------------------------------------------------------------------------
// wave_pulse_field_engine_top
// Table of travelling light pulses with tick, emit and query actions.
// ----------------------------------------------------------------------------
// One item at a time is worked by a small sequencer around a single shared
// 32x32 multiplier and a one-bit-per-cycle divider; the pulse table sits in a
// RAM with a registered read, and every slot visit passes a read state and an
// evaluate state. A tick makes two multiply and reciprocal passes for step and
// loss, then reads, updates and writes back each slot. An emit reads the slots
// in order and stops at the first free slot. A query reads every slot, and each
// live pulse needs two multiplies and a 16-step division. The result waits in
// an output register; a new item is taken once the sequencer is idle.
// Configuration writes are always taken.
module wave_pulse_field_engine_top #(
   parameter int MAX_PULSES = wpfe_pkg::MAX_PULSES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  wpfe_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output wpfe_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wpfe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [15:0]                          csr_wdata
);
   import wpfe_pkg::*;

   localparam int IW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
   localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_PULSES - 1);
   localparam int WW = 33;

   typedef enum logic [3:0] {
      S_IDLE, S_MSPD, S_RSPD, S_MDEC, S_RDEC, S_LOSS, S_READ, S_EVAL,
      S_SQ, S_FM, S_DEN, S_DIV, S_ACC, S_NEXT, S_DONE
   } state_type;

   state_type        state_ff;
   req_type          req_ff;
   logic [15:0]      track_ff, speed_ff, decay_ff, falloff_ff, thr_ff;
   logic [IW-1:0]    slot_ff;
   logic [MAX_PULSES-1:0] vld_ff;
   logic             rd_vld_ff;
   logic [63:0]      prod_ff;
   logic [22:0]      step_ff, loss_ff;
   logic [15:0]      d_ff;
   logic [48:0]      den_ff;
   logic [39:0]      num_ff;
   logic [15:0]      q_ff;
   logic [3:0]       bit_ff;
   logic [19:0]      sum_ff;
   logic             found_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [31:0]      mul_a, mul_b;
   logic [WW-1:0]    ram_rdata, wr_data;
   logic             wr_en, rd_en;
   logic [15:0]      cur_pos, cur_inten;
   logic             cur_bwd, live;
   logic [15:0]      pos_in, inten_in;
   logic             bwd_in;
   logic signed [25:0] np, refl;
   logic [63:0]      den_sh;
   logic [20:0]      sum_wide;

   // Pulse table
   wpfe_ram #(.WIDTH(WW), .DEPTH(MAX_PULSES), .AW(IW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_en     = (state_ff == S_READ);

   // Slot as read; a never-written slot reads as all zero
   assign cur_pos   = rd_vld_ff ? ram_rdata[15:0]  : 16'd0;
   assign cur_inten = rd_vld_ff ? ram_rdata[31:16] : 16'd0;
   assign cur_bwd   = rd_vld_ff ? ram_rdata[32]    : 1'b0;
   assign live      = (cur_inten >= thr_ff);

   // Shared multiplier operand selection
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         S_MSPD:         begin mul_a = {16'd0, speed_ff}; mul_b = {16'd0, req_ff.delta_ms}; end
         S_MDEC:         begin mul_a = {16'd0, decay_ff}; mul_b = {16'd0, req_ff.delta_ms}; end
         S_RSPD, S_RDEC: begin mul_a = prod_ff[31:0];     mul_b = DIV1000_MAGIC; end
         S_SQ:           begin mul_a = {16'd0, d_ff};     mul_b = {16'd0, d_ff}; end
         S_FM:           begin mul_a = {16'd0, falloff_ff}; mul_b = prod_ff[31:0]; end
         default:        begin mul_a = 32'd0;             mul_b = 32'd0; end
      endcase
   end

   // Tick update of one slot: move, reflect once, clamp, decay
   always_comb begin
      np = cur_bwd ? (26'($signed({1'b0, cur_pos})) - 26'($signed({1'b0, step_ff})))
                   : (26'($signed({1'b0, cur_pos})) + 26'($signed({1'b0, step_ff})));
      refl   = np;
      bwd_in = cur_bwd;
      if (np < 0) begin
         refl   = -np;
         bwd_in = ~cur_bwd;
      end else if (np > 26'($signed({1'b0, track_ff}))) begin
         refl   = 26'($signed({1'b0, track_ff, 1'b0})) - np;
         bwd_in = ~cur_bwd;
      end
      if (refl < 0) begin
         pos_in = 16'd0;
      end else if (refl > 26'($signed({1'b0, track_ff}))) begin
         pos_in = track_ff;
      end else begin
         pos_in = refl[15:0];
      end
      if ({7'd0, cur_inten} > loss_ff) begin
         inten_in = cur_inten - loss_ff[15:0];
      end else begin
         inten_in = 16'd0;
      end
   end

   // Table write in the evaluate cycle
   always_comb begin
      wr_en   = 1'b0;
      wr_data = {cur_bwd, cur_inten, cur_pos};
      if (state_ff == S_EVAL) begin
         if (req_ff.action == ACT_TICK) begin
            wr_en   = 1'b1;
            wr_data = live ? {bwd_in, inten_in, pos_in} : {cur_bwd, 16'd0, cur_pos};
         end else if (req_ff.action == ACT_EMIT && !live) begin
            wr_en   = 1'b1;
            wr_data = {1'b0, req_ff.start_intensity, req_ff.position};
         end
      end
   end

   assign den_sh   = {15'd0, den_ff} << bit_ff;
   assign sum_wide = {1'b0, sum_ff} + {5'd0, q_ff};

   // Sequencer, configuration and output register
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         track_ff     <= TRACK_LENGTH_RST;
         speed_ff     <= WAVE_SPEED_RST;
         decay_ff     <= DECAY_RATE_RST;
         falloff_ff   <= FALLOFF_RST;
         thr_ff       <= THRESHOLD_RST;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_TRACK_LENGTH: track_ff   <= csr_wdata;
               CSR_WAVE_SPEED:   speed_ff   <= csr_wdata;
               CSR_DECAY_RATE:   decay_ff   <= csr_wdata;
               CSR_FALLOFF:      falloff_ff <= csr_wdata;
               CSR_THRESHOLD:    thr_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            vld_ff[slot_ff] <= 1'b1;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  slot_ff  <= '0;
                  sum_ff   <= 20'd0;
                  found_ff <= 1'b0;
                  case (req_data.action)
                     ACT_TICK:  state_ff <= S_MSPD;
                     ACT_EMIT:  state_ff <= S_READ;
                     ACT_QUERY: state_ff <= S_READ;
                     default:   state_ff <= S_DONE;
                  endcase
               end
            end
            S_MSPD: state_ff <= S_RSPD;
            S_RSPD: state_ff <= S_MDEC;
            S_MDEC: begin
               step_ff  <= prod_ff[DIV1000_SHIFT+22:DIV1000_SHIFT];
               state_ff <= S_RDEC;
            end
            S_RDEC: state_ff <= S_LOSS;
            S_LOSS: begin
               loss_ff  <= prod_ff[DIV1000_SHIFT+22:DIV1000_SHIFT];
               state_ff <= S_READ;
            end
            S_READ: begin
               rd_vld_ff <= vld_ff[slot_ff];
               state_ff  <= S_EVAL;
            end
            S_EVAL: begin
               state_ff <= S_NEXT;
               if (req_ff.action == ACT_EMIT && !live) begin
                  found_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else if (req_ff.action == ACT_QUERY && live) begin
                  d_ff     <= (cur_pos >= req_ff.position) ? cur_pos - req_ff.position
                                                           : req_ff.position - cur_pos;
                  num_ff   <= {cur_inten, 24'd0};
                  state_ff <= S_SQ;
               end
            end
            S_SQ: state_ff <= S_FM;
            S_FM: state_ff <= S_DEN;
            S_DEN: begin
               den_ff   <= {1'b0, prod_ff[47:0]} + 49'h1000000;
               q_ff     <= 16'd0;
               bit_ff   <= 4'd15;
               state_ff <= S_DIV;
            end
            // Restoring division, one quotient bit a cycle
            S_DIV: begin
               if ({24'd0, num_ff} >= den_sh) begin
                  num_ff         <= 40'({24'd0, num_ff} - den_sh);
                  q_ff[bit_ff]   <= 1'b1;
               end
               if (bit_ff == 4'd0) begin
                  state_ff <= S_ACC;
               end else begin
                  bit_ff <= bit_ff - 4'd1;
               end
            end
            S_ACC: begin
               sum_ff   <= sum_wide[20] ? SUM_MAX : sum_wide[19:0];
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (slot_ff == LAST_SLOT) begin
                  state_ff <= S_DONE;
               end else begin
                  slot_ff  <= slot_ff + IW'(1);
                  state_ff <= S_READ;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.intensity_sum <= sum_ff;
                  rsp_data_ff.slot_found    <= found_ff;
                  state_ff                  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[hdl/wpfe_checker.sv]
// ----------------------------------------------------------------------------
// wpfe_checker
// Port-level checks of the wave pulse field engine, bound to the top level.
// ----------------------------------------------------------------------------
module wpfe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input wpfe_pkg::rsp_type              rsp_data,
   input logic                           csr_ready
);
   import wpfe_pkg::*;

   // An accepted item leaves the engine busy in the cycle after it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine ready right after taking an item");

   // A result never carries both a sum and a found slot
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.slot_found && rsp_data.intensity_sum != 20'd0))
      else $error("result mixes emit and query fields");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Register writes are always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

endmodule

bind wave_pulse_field_engine_top wpfe_checker u_wpfe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse field engine: directed and random tick,
// emit and query items under several handshake idling phases and register
// settings, with results checked against an in-bench pulse table model.
// ----------------------------------------------------------------------------

// Pulse table model and queue of predicted results
class pulse_field_board;
   logic [15:0] trk_len, speed, decay, falloff, thresh;
   logic [15:0] pos_tbl [16];
   logic [15:0] int_tbl [16];
   bit          back_tbl [16];
   wpfe_pkg::rsp_type pending [$];
   int          n_err;

   function new();
      trk_len = wpfe_pkg::TRACK_LENGTH_RST;
      speed   = wpfe_pkg::WAVE_SPEED_RST;
      decay   = wpfe_pkg::DECAY_RATE_RST;
      falloff = wpfe_pkg::FALLOFF_RST;
      thresh  = wpfe_pkg::THRESHOLD_RST;
      for (int k = 0; k < 16; k++) begin
         pos_tbl[k] = '0; int_tbl[k] = '0; back_tbl[k] = 0;
      end
      n_err = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
         wpfe_pkg::CSR_TRACK_LENGTH: trk_len = v;
         wpfe_pkg::CSR_WAVE_SPEED:   speed   = v;
         wpfe_pkg::CSR_DECAY_RATE:   decay   = v;
         wpfe_pkg::CSR_FALLOFF:      falloff = v;
         wpfe_pkg::CSR_THRESHOLD:    thresh  = v;
         default: ;
      endcase
   endfunction

   // Work out the result of one accepted item and update the table
   function void note_item(wpfe_pkg::req_type r);
      wpfe_pkg::rsp_type res;
      longint step, loss, np, lenv, d, den, term, sum;
      res = '0;
      case (r.action)
         wpfe_pkg::ACT_TICK: begin
            step = (longint'(speed) * r.delta_ms) / 1000;
            loss = (longint'(decay) * r.delta_ms) / 1000;
            lenv = trk_len;
            for (int k = 0; k < 16; k++) begin
               if (int_tbl[k] < thresh) begin
                  int_tbl[k] = '0;
                  continue;
               end
               np = longint'(pos_tbl[k]) + (back_tbl[k] ? -step : step);
               if (np < 0 || np > lenv) begin
                  np = (np < 0) ? -np : 2 * lenv - np;
                  back_tbl[k] = !back_tbl[k];
                  if (np < 0) np = 0;
                  if (np > lenv) np = lenv;
               end
               pos_tbl[k] = np[15:0];
               int_tbl[k] = (longint'(int_tbl[k]) > loss) ? int_tbl[k] - loss[15:0] : '0;
            end
         end
         wpfe_pkg::ACT_EMIT: begin
            for (int k = 0; k < 16; k++) begin
               if (int_tbl[k] < thresh) begin
                  int_tbl[k] = r.start_intensity;
                  pos_tbl[k] = r.position;
                  back_tbl[k] = 0;
                  res.slot_found = 1'b1;
                  break;
               end
            end
         end
         wpfe_pkg::ACT_QUERY: begin
            sum = 0;
            for (int k = 0; k < 16; k++) begin
               if (int_tbl[k] < thresh) continue;
               d = (pos_tbl[k] >= r.position) ? pos_tbl[k] - r.position
                                              : r.position - pos_tbl[k];
               den = (longint'(1) << 24) + longint'(falloff) * (d * d);
               term = (longint'(int_tbl[k]) << 24) / den;
               sum += term;
               if (sum > 1048575) sum = 1048575;
            end
            res.intensity_sum = sum[19:0];
         end
         default: ;
      endcase
      pending.push_back(res);
   endfunction

   function void check_result(wpfe_pkg::rsp_type got);
      wpfe_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $error("unexpected result %h", got);
         n_err++;
         return;
      end
      want = pending.pop_front();
      if (got.intensity_sum !== want.intensity_sum) begin
         $error("intensity_sum: expected %0d, got %0d", want.intensity_sum,
                got.intensity_sum);
         n_err++;
      end
      if (got.slot_found !== want.slot_found) begin
         $error("slot_found: expected %0d, got %0d", want.slot_found, got.slot_found);
         n_err++;
      end
   endfunction
endclass

module tb;
   import wpfe_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic req_ready, rsp_valid, csr_ready;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int send_idle = 0;   // percent of cycles the sender holds back
   int recv_stall = 0;  // percent of cycles the receiver stalls
   bit hold_off = 0;    // long receiver hold-off in progress
   int quiet_cycles = 0;
   pulse_field_board board = new();

   wave_pulse_field_engine_top u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || hold_off)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // The block is busy after each item until it is idle again, so the edge
   // taken at the start costs no throughput
   task automatic send_item(req_type r);
      @(posedge clock);
      while ($urandom_range(99) < send_idle) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.note_item(r);
      req_valid <= 1'b0;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, v);
      csr_valid <= 1'b0;
   endtask

   // Wait for all results, then let a possibly busy block settle
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   function automatic req_type make_item(logic [1:0] act, logic [15:0] ms,
                                         logic [15:0] inten, logic [15:0] pos);
      req_type r;
      r.action = act; r.delta_ms = ms; r.start_intensity = inten; r.position = pos;
      return r;
   endfunction

   // Mostly small ticks and on-track pulses, now and then full-range fields
   function automatic req_type rand_item();
      req_type r;
      int sel;
      sel = $urandom_range(99);
      r.start_intensity = ($urandom_range(9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(8192, 256));
      r.position = ($urandom_range(9) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(board.trk_len));
      r.delta_ms = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(300));
      if (sel < 30)      r.action = ACT_TICK;
      else if (sel < 60) r.action = ACT_EMIT;
      else if (sel < 97) r.action = ACT_QUERY;
      else               r.action = 2'd3;
      return r;
   endfunction

   task automatic random_phase(int n, int idle, int stall);
      send_idle = idle;
      recv_stall = stall;
      repeat (n) send_item(rand_item());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of fields, every action, special cases
      send_item(make_item(ACT_QUERY, 16'h0, 16'h0, 16'h0));
      send_item(make_item(ACT_EMIT, 16'h0, 16'hFFFF, 16'h0));
      send_item(make_item(ACT_EMIT, 16'hFFFF, 16'h1000, 16'hFFFF));   // beyond track
      send_item(make_item(ACT_EMIT, 16'h0, 16'h0, 16'h0600));         // stays free
      send_item(make_item(ACT_QUERY, 16'h0, 16'h0, 16'h0));
      send_item(make_item(ACT_QUERY, 16'h0, 16'h0, 16'hFFFF));
      send_item(make_item(ACT_TICK, 16'd100, 16'h0, 16'h0));
      send_item(make_item(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));       // unused code
      send_item(make_item(ACT_TICK, 16'hFFFF, 16'h0, 16'h0));         // large tick
      send_item(make_item(ACT_QUERY, 16'h0, 16'h0, 16'h0C00));
      for (int k = 0; k < 17; k++)                                    // table full
         send_item(make_item(ACT_EMIT, 16'h0, 16'hF000, 16'(k * 160)));
      send_item(make_item(ACT_QUERY, 16'h0, 16'h0, 16'h0500));
      drain();

      // Zero falloff adds each live pulse at full intensity; zero threshold counts every slot
      write_csr(CSR_FALLOFF, 16'h0);
      send_item(make_item(ACT_QUERY, 16'h0, 16'h0, 16'h0100));
      drain();
      write_csr(CSR_THRESHOLD, 16'h0);
      send_item(make_item(ACT_EMIT, 16'h0, 16'h1000, 16'h0));
      send_item(make_item(ACT_QUERY, 16'h0, 16'h0, 16'h0));
      drain();
      write_csr(CSR_THRESHOLD, 16'hFFFF);
      write_csr(CSR_TRACK_LENGTH, 16'h0);
      send_item(make_item(ACT_TICK, 16'd50, 16'h0, 16'h0));
      drain();

      // Reset-like settings: flush table with a huge decay tick
      write_csr(CSR_THRESHOLD, 16'h1);
      write_csr(CSR_TRACK_LENGTH, TRACK_LENGTH_RST);
      write_csr(CSR_FALLOFF, FALLOFF_RST);
      write_csr(CSR_DECAY_RATE, 16'hFFFF);
      send_item(make_item(ACT_TICK, 16'hFFFF, 16'h0, 16'h0));
      drain();
      write_csr(CSR_DECAY_RATE, DECAY_RATE_RST);
      random_phase(250, 0, 0);
      drain();

      // Pressure: long receiver hold-off while items keep coming
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         random_phase(20, 0, 0);
      join
      drain();

      write_csr(CSR_WAVE_SPEED, 16'hFFFF);
      write_csr(CSR_TRACK_LENGTH, 16'hFFFF);
      write_csr(CSR_DECAY_RATE, 16'h0100);
      random_phase(250, 70, 0);
      drain();

      write_csr(CSR_WAVE_SPEED, 16'h0);
      write_csr(CSR_TRACK_LENGTH, 16'h1);
      write_csr(CSR_FALLOFF, 16'hFFFF);
      write_csr(CSR_THRESHOLD, 16'h0800);
      random_phase(250, 0, 70);
      drain();

      write_csr(CSR_WAVE_SPEED, 16'h0800);
      write_csr(CSR_TRACK_LENGTH, 16'h2000);
      write_csr(CSR_DECAY_RATE, 16'h0);
      write_csr(CSR_FALLOFF, 16'h0010);
      write_csr(CSR_THRESHOLD, 16'h1);
      random_phase(250, 28, 28);
      drain();

      write_csr(CSR_DECAY_RATE, 16'h4000);
      random_phase(250, 0, 0);
      drain();

      if (board.n_err == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

[wave_pulse_field_engine_top.f]
hdl/wpfe_pkg.sv
hdl/wpfe_ram.sv
hdl/wave_pulse_field_engine_top.sv
hdl/wpfe_checker.sv
dv/tb.sv
